// ===== rtl/core/dtls_new_cid_message_validator_macros.svh =====
// Assertion macros shared by the NewConnectionId validator RTL.
// No dependencies; included by the modules that carry assertions.
`ifndef DTLS_NEW_CID_MESSAGE_VALIDATOR_MACROS_SVH
`define DTLS_NEW_CID_MESSAGE_VALIDATOR_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define DNCV_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled during reset.
`define DNCV_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/core/dncv_pkg.sv =====
// Package for the NewConnectionId validator: codes, sizes and the
// front-to-back summary record. No dependencies.
package dncv_pkg;

    localparam int unsigned COUNT_W     = 17;
    localparam int unsigned LEN_W       = 16;
    localparam int unsigned QUEUE_DEPTH = 2;
    localparam int unsigned QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int unsigned QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    localparam logic [COUNT_W-1:0] COUNT_MAX    = {COUNT_W{1'b1}};
    localparam logic [COUNT_W-1:0] MIN_TOTAL    = COUNT_W'(3);
    localparam logic [COUNT_W-1:0] PREFIX_BYTES = COUNT_W'(2);

    typedef enum logic [1:0] {
        ERR_NONE    = 2'd0,
        ERR_ZERO    = 2'd1,
        ERR_OVERRUN = 2'd2
    } entry_err_t;

    typedef enum logic [2:0] {
        ST_OK         = 3'd0,
        ST_SHORT      = 3'd1,
        ST_MISMATCH   = 3'd2,
        ST_ZERO_CID   = 3'd3,
        ST_MALFORMED  = 3'd4,
        ST_BAD_USAGE  = 3'd5,
        ST_IMM_EMPTY  = 3'd6
    } status_t;

    typedef enum logic [1:0] {
        AL_NONE          = 2'd0,
        AL_DECODE_ERROR  = 2'd1,
        AL_ILLEGAL_PARAM = 2'd2
    } alert_t;

    // Everything the back end needs to rank errors for one message.
    typedef struct packed {
        logic             too_short;
        logic             len_mismatch;
        entry_err_t       entry_err;
        logic             bad_usage;
        logic             usage_bit;
        logic [LEN_W-1:0] vector_len;
    } summary_t;

endpackage

// ===== rtl/core/dncv_if.sv =====
// Valid/ready channel interfaces for the validator's byte input and result output.
// Depends on nothing.
interface dncv_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       last_byte;

    modport source (output valid, output data_byte, output last_byte, input ready);
    modport sink   (input valid, input data_byte, input last_byte, output ready);
endinterface

interface dncv_out_if;
    logic        valid;
    logic        ready;
    logic [2:0]  status;
    logic [1:0]  alert_class;
    logic [15:0] cids_length;
    logic        usage;

    modport source (output valid, output status, output alert_class,
                    output cids_length, output usage, input ready);
    modport sink   (input valid, input status, input alert_class,
                    input cids_length, input usage, output ready);
endinterface

// ===== rtl/core/dncv_front.sv =====
// Front end: takes message bytes, walks the CID vector, and pushes one
// summary per message into the queue. Depends on dncv_pkg and the macros header.
`include "dtls_new_cid_message_validator_macros.svh"

module dncv_front
    import dncv_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       valid,
    output logic       ready,
    input  logic [7:0] data_byte,
    input  logic       last_byte,
    input  logic       queue_full,
    output logic       push,
    output summary_t   push_data
);

    logic [COUNT_W-1:0] count_reg, count_next;
    logic [LEN_W-1:0]   vlen_reg, vlen_next;
    logic [LEN_W-1:0]   pos_reg, pos_next;
    logic [7:0]         rem_reg, rem_next;
    entry_err_t         err_reg, err_next;
    logic [7:0]         use_reg, use_next;
    logic               accept;
    logic [COUNT_W-1:0] entry_end;

    assign ready  = !queue_full;
    assign accept = valid && ready;
    assign push   = accept && last_byte;

    // End of a new entry measured from the vector start: position + 1 + length.
    assign entry_end = {1'b0, pos_reg} + COUNT_W'(1) + {{(COUNT_W-8){1'b0}}, data_byte};

    always_comb
    begin
        vlen_next = vlen_reg;
        pos_next  = pos_reg;
        rem_next  = rem_reg;
        err_next  = err_reg;
        use_next  = use_reg;
        if (count_reg == '0)
        begin
            vlen_next = {data_byte, 8'h00};
        end
        else if (count_reg == COUNT_W'(1))
        begin
            vlen_next = {vlen_reg[15:8], data_byte};
        end
        else if (pos_reg < vlen_reg)
        begin
            if (err_reg == ERR_NONE)
            begin
                if (rem_reg == '0)
                begin
                    if (data_byte == '0)
                        err_next = ERR_ZERO;
                    else if (entry_end > {1'b0, vlen_reg})
                        err_next = ERR_OVERRUN;
                    else
                        rem_next = data_byte;
                end
                else
                begin
                    rem_next = rem_reg - 8'd1;
                end
            end
            pos_next = pos_reg + LEN_W'(1);
        end
        else if (count_reg == {1'b0, vlen_reg} + PREFIX_BYTES)
        begin
            use_next = data_byte;
        end
        count_next = (count_reg == COUNT_MAX) ? count_reg : count_reg + COUNT_W'(1);
    end

    always_comb
    begin
        push_data.too_short    = count_next < MIN_TOTAL;
        push_data.len_mismatch = count_next != ({1'b0, vlen_next} + MIN_TOTAL);
        push_data.entry_err    = err_next;
        push_data.bad_usage    = use_next > 8'd1;
        push_data.usage_bit    = use_next[0];
        push_data.vector_len   = vlen_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
            vlen_reg  <= '0;
            pos_reg   <= '0;
            rem_reg   <= '0;
            err_reg   <= ERR_NONE;
            use_reg   <= '0;
        end
        else if (accept)
        begin
            if (last_byte)
            begin
                count_reg <= '0;
                vlen_reg  <= '0;
                pos_reg   <= '0;
                rem_reg   <= '0;
                err_reg   <= ERR_NONE;
                use_reg   <= '0;
            end
            else
            begin
                count_reg <= count_next;
                vlen_reg  <= vlen_next;
                pos_reg   <= pos_next;
                rem_reg   <= rem_next;
                err_reg   <= err_next;
                use_reg   <= use_next;
            end
        end
    end

    `DNCV_ASSERT_NEXT(a_clear_after_last, clk, rst_n, push,
        (count_reg == '0) && (err_reg == ERR_NONE), "walker not cleared after final beat")
    `DNCV_ASSERT_NOW(a_pos_bounded, clk, rst_n, count_reg > COUNT_W'(1),
        pos_reg <= vlen_reg, "vector position ran past vector length")
    `DNCV_ASSERT_NOW(a_no_push_full, clk, rst_n, queue_full, !push,
        "push into a full queue")

endmodule

// ===== rtl/core/dncv_queue.sv =====
// Short summary queue between front and back ends, flop based.
// Depends on dncv_pkg and the macros header.
`include "dtls_new_cid_message_validator_macros.svh"

module dncv_queue
    import dncv_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     push,
    input  summary_t push_data,
    output logic     full,
    input  logic     pop,
    output summary_t pop_data,
    output logic     empty
);

    summary_t           entry_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0]  wr_ptr_reg, rd_ptr_reg;
    logic [QCNT_W-1:0]  count_reg;
    logic               do_push, do_pop;

    assign full     = count_reg == QCNT_W'(QUEUE_DEPTH);
    assign empty    = count_reg == '0;
    assign do_push  = push && !full;
    assign do_pop   = pop && !empty;
    assign pop_data = entry_reg[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (do_push)
            entry_reg[wr_ptr_reg] <= push_data;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_push)
                wr_ptr_reg <= (wr_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0
                                                                      : wr_ptr_reg + QPTR_W'(1);
            if (do_pop)
                rd_ptr_reg <= (rd_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0
                                                                      : rd_ptr_reg + QPTR_W'(1);
            if (do_push && !do_pop)
                count_reg <= count_reg + QCNT_W'(1);
            else if (do_pop && !do_push)
                count_reg <= count_reg - QCNT_W'(1);
        end
    end

    `DNCV_ASSERT_NOW(a_count_bounded, clk, rst_n, 1'b1,
        count_reg <= QCNT_W'(QUEUE_DEPTH), "queue count above depth")
    `DNCV_ASSERT_NOW(a_ptrs_match_empty, clk, rst_n, empty,
        wr_ptr_reg == rd_ptr_reg, "pointers differ while empty")

endmodule

// ===== rtl/core/dncv_back.sv =====
// Back end: ranks the errors of one message summary and holds the result
// in the output register. Depends on dncv_pkg and the macros header.
`include "dtls_new_cid_message_validator_macros.svh"

module dncv_back
    import dncv_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             queue_empty,
    input  summary_t         head,
    output logic             pop,
    output logic             valid,
    input  logic             ready,
    output logic [2:0]       status,
    output logic [1:0]       alert_class,
    output logic [LEN_W-1:0] cids_length,
    output logic             usage
);

    logic             valid_reg;
    status_t          status_reg, status_next;
    alert_t           alert_reg, alert_next;
    logic [LEN_W-1:0] len_reg, len_next;
    logic             usage_reg, usage_next;

    assign pop = !queue_empty && (!valid_reg || ready);

    always_comb
    begin
        status_next = ST_OK;
        alert_next  = AL_NONE;
        len_next    = '0;
        usage_next  = 1'b0;
        if (head.too_short)
        begin
            status_next = ST_SHORT;
            alert_next  = AL_DECODE_ERROR;
        end
        else if (head.len_mismatch)
        begin
            status_next = ST_MISMATCH;
            alert_next  = AL_DECODE_ERROR;
        end
        else if (head.entry_err == ERR_ZERO)
        begin
            status_next = ST_ZERO_CID;
            alert_next  = AL_ILLEGAL_PARAM;
        end
        else if (head.entry_err == ERR_OVERRUN)
        begin
            status_next = ST_MALFORMED;
            alert_next  = AL_DECODE_ERROR;
        end
        else if (head.bad_usage)
        begin
            status_next = ST_BAD_USAGE;
            alert_next  = AL_ILLEGAL_PARAM;
        end
        else if (head.vector_len == '0 && !head.usage_bit)
        begin
            status_next = ST_IMM_EMPTY;
            alert_next  = AL_ILLEGAL_PARAM;
        end
        else
        begin
            len_next   = head.vector_len;
            usage_next = head.usage_bit;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (pop)
        begin
            valid_reg <= 1'b1;
        end
        else if (ready)
        begin
            valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            status_reg <= status_next;
            alert_reg  <= alert_next;
            len_reg    <= len_next;
            usage_reg  <= usage_next;
        end
    end

    assign valid       = valid_reg;
    assign status      = status_reg;
    assign alert_class = alert_reg;
    assign cids_length = len_reg;
    assign usage       = usage_reg;

    `DNCV_ASSERT_NOW(a_ok_no_alert, clk, rst_n, valid_reg,
        (status_reg == ST_OK) == (alert_reg == AL_NONE), "status and alert disagree")
    `DNCV_ASSERT_NOW(a_err_zero_fields, clk, rst_n, valid_reg && (status_reg != ST_OK),
        (len_reg == '0) && !usage_reg, "length or usage set on an error result")

endmodule

// ===== rtl/core/dtls_new_cid_message_validator.sv =====
// Top level of the DTLS 1.3 NewConnectionId message validator.
// Depends on dncv_pkg, dncv_if, dncv_front, dncv_queue and dncv_back.
//
//   channel  | dir | beat payload                               | beats
//   ---------+-----+--------------------------------------------+-------------------
//   msg      | in  | data_byte[7:0], last_byte                  | one per body byte
//   result   | out | status[2:0], alert_class[1:0],             | one per message
//            |     | cids_length[15:0], usage                   |
//
// Timing: one byte beat per cycle while the queue has room, no gaps between
// messages. The walker does a single compare-and-update per byte, so throughput
// is one beat per clock unless the queue is full. A message's result passes
// through the queue, then the output register in the back end.
// Reset clears the walker, the queue and the output valid; input ready is high
// from reset on, since the queue starts empty.
// Stalls: the back end holds a result until it is taken; up to two more message
// summaries wait in the queue; the input stalls only while that queue is full.
//
// Structure: dncv_front walks the connection-ID vector byte by byte and folds
// each message into a summary (short, length mismatch, first entry error,
// usage checks, vector length). dncv_queue decouples it from dncv_back, which
// ranks the errors into status and alert class and drives the result channel.

module dtls_new_cid_message_validator
    import dncv_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    dncv_in_if.sink     msg,
    dncv_out_if.source  result
);

    logic     queue_full;
    logic     queue_empty;
    logic     push;
    logic     pop;
    summary_t push_data;
    summary_t head;

    dncv_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .valid      (msg.valid),
        .ready      (msg.ready),
        .data_byte  (msg.data_byte),
        .last_byte  (msg.last_byte),
        .queue_full (queue_full),
        .push       (push),
        .push_data  (push_data)
    );

    dncv_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data (push_data),
        .full      (queue_full),
        .pop       (pop),
        .pop_data  (head),
        .empty     (queue_empty)
    );

    dncv_back u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .queue_empty (queue_empty),
        .head        (head),
        .pop         (pop),
        .valid       (result.valid),
        .ready       (result.ready),
        .status      (result.status),
        .alert_class (result.alert_class),
        .cids_length (result.cids_length),
        .usage       (result.usage)
    );

endmodule

// ===== bench/dncv_result_checker.sv =====
`timescale 1ns / 100ps
// Result checker for the NewConnectionId validator: watches the byte and result
// channels, predicts each message verdict and compares it. Depends on dncv_pkg, dncv_if.
module dncv_result_checker
    import dncv_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    dncv_in_if         msg,
    dncv_out_if        result,
    output int         fail_count,
    output int         pending,
    output int         beats_seen,
    output int         results_seen,
    output logic [6:0] status_seen
);

    typedef struct {
        status_t     status;
        alert_t      alert;
        logic [15:0] cids_len;
        logic        usage;
    } cid_verdict_t;

    // Walker state of the predictor.
    logic [COUNT_W-1:0] byte_cnt;
    logic [LEN_W-1:0]   vec_len;
    logic [LEN_W-1:0]   vec_pos;
    logic [7:0]         entry_left;
    entry_err_t         entry_err;
    logic [7:0]         usage_byte;

    cid_verdict_t expected_verdicts[$];

    assign pending = expected_verdicts.size();

    function automatic void clear_walk();
        byte_cnt   = '0;
        vec_len    = '0;
        vec_pos    = '0;
        entry_left = '0;
        entry_err  = ERR_NONE;
        usage_byte = '0;
    endfunction

    // Folds one body byte into the walk; returns 1 with a verdict on the final byte.
    function automatic logic fold_byte(input logic [7:0] b, input logic last,
                                       output cid_verdict_t v);
        v = '{ST_OK, AL_NONE, 16'd0, 1'b0};
        if (byte_cnt == 0)
            vec_len = {b, 8'h00};
        else if (byte_cnt == 1)
            vec_len[7:0] = b;
        else if (vec_pos < vec_len)
        begin
            if (entry_err == ERR_NONE)
            begin
                if (entry_left == 0)
                begin
                    if (b == 8'd0)
                        entry_err = ERR_ZERO;
                    else if (32'(vec_pos) + 32'd1 + 32'(b) > 32'(vec_len))
                        entry_err = ERR_OVERRUN;
                    else
                        entry_left = b;
                end
                else
                    entry_left = entry_left - 8'd1;
            end
            vec_pos = vec_pos + 16'd1;
        end
        else if (byte_cnt == PREFIX_BYTES + vec_len)
            usage_byte = b;

        if (byte_cnt != COUNT_MAX)
            byte_cnt = byte_cnt + 1'b1;

        if (!last)
            return 1'b0;

        if (byte_cnt < MIN_TOTAL)
            v = '{ST_SHORT, AL_DECODE_ERROR, 16'd0, 1'b0};
        else if (byte_cnt != MIN_TOTAL + vec_len)
            v = '{ST_MISMATCH, AL_DECODE_ERROR, 16'd0, 1'b0};
        else if (entry_err == ERR_ZERO)
            v = '{ST_ZERO_CID, AL_ILLEGAL_PARAM, 16'd0, 1'b0};
        else if (entry_err == ERR_OVERRUN)
            v = '{ST_MALFORMED, AL_DECODE_ERROR, 16'd0, 1'b0};
        else if (usage_byte > 8'd1)
            v = '{ST_BAD_USAGE, AL_ILLEGAL_PARAM, 16'd0, 1'b0};
        else if (vec_len == 0 && usage_byte == 8'd0)
            v = '{ST_IMM_EMPTY, AL_ILLEGAL_PARAM, 16'd0, 1'b0};
        else
            v = '{ST_OK, AL_NONE, vec_len, usage_byte[0]};
        clear_walk();
        return 1'b1;
    endfunction

    initial
    begin
        fail_count   = 0;
        beats_seen   = 0;
        results_seen = 0;
        status_seen  = '0;
        clear_walk();
    end

    always @(posedge clk)
    begin : watch
        cid_verdict_t exp_v;
        cid_verdict_t new_v;
        if (!rst_n)
            clear_walk();
        else
        begin
            // Check the result side first so a result can never match its own message's
            // prediction pushed in the same edge.
            if (result.valid && result.ready)
            begin
                results_seen++;
                if (expected_verdicts.size() == 0)
                begin
                    $error("result beat with no verdict outstanding");
                    fail_count++;
                end
                else
                begin
                    exp_v = expected_verdicts.pop_front();
                    status_seen[exp_v.status] = 1'b1;
                    if (result.status !== exp_v.status)
                    begin
                        $error("status: expected %0d, actual %0d", exp_v.status, result.status);
                        fail_count++;
                    end
                    if (result.alert_class !== exp_v.alert)
                    begin
                        $error("alert_class: expected %0d, actual %0d",
                               exp_v.alert, result.alert_class);
                        fail_count++;
                    end
                    if (result.cids_length !== exp_v.cids_len)
                    begin
                        $error("cids_length: expected %0d, actual %0d",
                               exp_v.cids_len, result.cids_length);
                        fail_count++;
                    end
                    if (result.usage !== exp_v.usage)
                    begin
                        $error("usage: expected %0d, actual %0d", exp_v.usage, result.usage);
                        fail_count++;
                    end
                end
            end
            if (msg.valid && msg.ready)
            begin
                beats_seen++;
                if (fold_byte(msg.data_byte, msg.last_byte, new_v))
                    expected_verdicts.push_back(new_v);
            end
        end
    end

endmodule

// ===== bench/dtls_new_cid_message_validator_test.sv =====
`timescale 1ns / 100ps
// Top of the NewConnectionId validator bench: clock, reset, message stimulus,
// result back-pressure, watchdog and verdict. Depends on dncv_if and dncv_result_checker.
module dtls_new_cid_message_validator_test;

    // Cycles with no beat on either channel before the run is declared hung.
    // Worst honest wait is a sender gap or a receiver stall times a few.
    localparam int IDLE_LIMIT = 5000;
    localparam int RANDOM_BEATS = 525;

    logic clk = 1'b0;
    logic rst_n;

    dncv_in_if  msg_ch ();
    dncv_out_if res_ch ();

    int         fail_count;
    int         pending;
    int         beats_seen;
    int         results_seen;
    logic [6:0] status_seen;

    // Body of the message under construction and where its entries start
    // (offsets inside the connection-ID vector).
    logic [7:0] body[$];
    int         entry_starts[$];

    int  msgs_sent;
    int  burst_left;
    bit  gaps_on;
    int  idle_cycles;

    always #1 clk = ~clk;

    dtls_new_cid_message_validator u_dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .msg    (msg_ch),
        .result (res_ch)
    );

    dncv_result_checker u_chk (
        .clk          (clk),
        .rst_n        (rst_n),
        .msg          (msg_ch),
        .result       (res_ch),
        .fail_count   (fail_count),
        .pending      (pending),
        .beats_seen   (beats_seen),
        .results_seen (results_seen),
        .status_seen  (status_seen)
    );

    // Hang detector: any beat on either side resets the count.
    always @(posedge clk)
    begin
        if (!rst_n)
            idle_cycles <= 0;
        else if ((msg_ch.valid && msg_ch.ready) || (res_ch.valid && res_ch.ready))
            idle_cycles <= 0;
        else if (idle_cycles >= IDLE_LIMIT)
        begin
            $display("watchdog: no beat for %0d cycles", IDLE_LIMIT);
            $display("*** FAILED ***");
            $finish;
        end
        else
            idle_cycles <= idle_cycles + 1;
    end

    // Result back-pressure. The mode changes at random intervals:
    // always ready, random drops, or runs of stalls.
    initial
    begin : ready_pattern
        int mode;
        int mode_left;
        int stall_left;
        mode       = 0;
        mode_left  = 0;
        stall_left = 0;
        res_ch.ready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (mode_left == 0)
            begin
                mode      = $urandom_range(0, 2);
                mode_left = $urandom_range(50, 300);
            end
            mode_left--;
            case (mode)
                0: res_ch.ready = 1'b1;
                1: res_ch.ready = ($urandom_range(0, 3) != 0);
                default:
                begin
                    if (stall_left > 0)
                    begin
                        res_ch.ready = 1'b0;
                        stall_left--;
                    end
                    else
                    begin
                        res_ch.ready = 1'b1;
                        stall_left   = $urandom_range(1, 12);
                    end
                end
            endcase
        end
    end

    // One byte beat. Called at a falling edge; returns at the falling edge after
    // the beat was taken, with valid still high so back-to-back beats stay high.
    task automatic send_beat(input logic [7:0] b, input logic last);
        if (gaps_on && burst_left == 0)
        begin
            msg_ch.valid = 1'b0;
            repeat ($urandom_range(1, 8)) @(negedge clk);
            burst_left = $urandom_range(1, 24);
        end
        msg_ch.valid     = 1'b1;
        msg_ch.data_byte = b;
        msg_ch.last_byte = last;
        do
            @(posedge clk);
        while (!msg_ch.ready);
        @(negedge clk);
        if (burst_left > 0)
            burst_left--;
    endtask

    task automatic send_body();
        for (int i = 0; i < body.size(); i++)
            send_beat(body[i], i == body.size() - 1);
        msgs_sent++;
        body.delete();
    endtask

    task automatic start_message(input int vlen);
        body.delete();
        body.push_back(vlen[15:8]);
        body.push_back(vlen[7:0]);
    endtask

    // Fills exactly vlen bytes with well-formed entries; vlen of 1 cannot be filled.
    task automatic build_vector(input int vlen);
        int rem;
        int n;
        int len;
        rem = vlen;
        entry_starts.delete();
        while (rem > 1)
        begin
            n   = (rem - 1 > 255) ? 255 : rem - 1;
            len = $urandom_range(1, n);
            // never leave a single byte, it could not form an entry
            if (rem - 1 - len == 1)
                len = (len > 1) ? len - 1 : len + 1;
            entry_starts.push_back(vlen - rem);
            body.push_back(len[7:0]);
            repeat (len) body.push_back(8'($urandom_range(0, 255)));
            rem -= 1 + len;
        end
    endtask

    task automatic make_wellformed(input int vlen, input logic [7:0] usage_val);
        start_message(vlen);
        build_vector(vlen);
        body.push_back(usage_val);
    endtask

    // Turns one entry length into zero (zero-length entry).
    task automatic corrupt_zero();
        int k;
        k = $urandom_range(0, entry_starts.size() - 1);
        body[2 + entry_starts[k]] = 8'd0;
    endtask

    // Makes the last entry able to overrun claim too many bytes, else zeroes an entry.
    task automatic corrupt_overrun(input int vlen);
        int k;
        k = -1;
        foreach (entry_starts[i])
            if (vlen - entry_starts[i] <= 255)
                k = i;
        if (k < 0)
            corrupt_zero();
        else
            body[2 + entry_starts[k]] = 8'($urandom_range(vlen - entry_starts[k], 255));
    endtask

    task automatic send_bytes(input logic [7:0] b0, input logic [7:0] b1,
                              input logic [7:0] b2, input int count);
        body.delete();
        if (count > 0) body.push_back(b0);
        if (count > 1) body.push_back(b1);
        if (count > 2) body.push_back(b2);
    endtask

    task automatic random_vlen(output int vlen);
        vlen = $urandom_range(0, 24);
        if (vlen == 1)
            vlen = 2;
    endtask

    task automatic random_message();
        int kind;
        int vlen;
        int n;
        kind = $urandom_range(0, 99);
        random_vlen(vlen);
        if (kind < 55)
            // mostly legal usage, now and then an out-of-range one
            make_wellformed(vlen, ($urandom_range(0, 99) < 85) ? 8'($urandom_range(0, 1))
                                                                : 8'($urandom_range(2, 255)));
        else if (kind < 65)
        begin
            if (vlen < 2) vlen = $urandom_range(2, 24);
            make_wellformed(vlen, 8'($urandom_range(0, 3)));
            corrupt_zero();
        end
        else if (kind < 75)
        begin
            if (vlen < 2) vlen = $urandom_range(2, 24);
            make_wellformed(vlen, 8'($urandom_range(0, 3)));
            corrupt_overrun(vlen);
        end
        else if (kind < 83)
        begin
            make_wellformed(vlen, 8'($urandom_range(0, 1)));
            n = $urandom_range(1, 3);
            if ($urandom_range(0, 1))
                repeat (n) body.push_back(8'($urandom_range(0, 255)));
            else
                repeat (n) if (body.size() > 1) void'(body.pop_back());
        end
        else if (kind < 88)
            send_bytes(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)), 8'd0,
                       $urandom_range(1, 2));
        else if (kind < 93)
            send_bytes(8'd0, 8'd0, 8'($urandom_range(0, 2)), 3);
        else
        begin
            // raw noise with an arbitrary length prefix
            body.delete();
            repeat ($urandom_range(1, 12)) body.push_back(8'($urandom_range(0, 255)));
        end
        send_body();
    endtask

    initial
    begin : stimulus
        int start_beats;
        msg_ch.valid     = 1'b0;
        msg_ch.data_byte = 8'h00;
        msg_ch.last_byte = 1'b0;
        rst_n      = 1'b0;
        msgs_sent  = 0;
        burst_left = 0;
        gaps_on    = 1'b1;

        repeat (6) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // ---- directed ----
        // final flag on the first and on the second byte
        send_bytes(8'h00, 8'h00, 8'h00, 1); send_body();
        send_bytes(8'hFF, 8'hFF, 8'h00, 2); send_body();
        // empty vector: immediate (illegal), spare (ok), usage out of range
        send_bytes(8'h00, 8'h00, 8'h00, 3); send_body();
        send_bytes(8'h00, 8'h00, 8'h01, 3); send_body();
        send_bytes(8'h00, 8'h00, 8'h02, 3); send_body();
        send_bytes(8'h00, 8'h00, 8'hFF, 3); send_body();
        // one 1-byte ID, both usages
        body = '{8'h00, 8'h02, 8'h01, 8'hAA, 8'h00}; send_body();
        body = '{8'h00, 8'h02, 8'h01, 8'h55, 8'h01}; send_body();
        // zero-length entry, then the walk must ignore the trailing bytes
        body = '{8'h00, 8'h02, 8'h00, 8'h00, 8'h01}; send_body();
        // zero-length entry outranks a bad usage byte
        body = '{8'h00, 8'h03, 8'h00, 8'h02, 8'h07, 8'h05}; send_body();
        // entry that overruns the vector, and a one-byte vector whose entry overruns it
        body = '{8'h00, 8'h02, 8'h05, 8'h00, 8'h01}; send_body();
        body = '{8'h00, 8'h01, 8'h01, 8'h01}; send_body();
        // overrun with bad usage: overrun wins
        body = '{8'h00, 8'h02, 8'hFF, 8'h00, 8'h09}; send_body();
        // bytes after the usage byte, and a message cut off inside the vector
        body = '{8'h00, 8'h00, 8'h01, 8'h77}; send_body();
        body = '{8'h00, 8'h04, 8'h01, 8'hAA}; send_body();
        // mismatch outranks a zero entry
        body = '{8'h00, 8'h04, 8'h00, 8'h00, 8'h01}; send_body();
        // vector longer than one byte of length: entries of up to 255 bytes
        make_wellformed(300, 8'h01);
        send_body();
        make_wellformed(16'h0100, 8'h00);
        send_body();

        // ---- random ----
        start_beats = beats_seen;
        while (beats_seen - start_beats < RANDOM_BEATS)
        begin
            // one message in five goes out as a solid burst
            gaps_on = ($urandom_range(0, 4) != 0);
            random_message();
        end
        msg_ch.valid     = 1'b0;
        msg_ch.last_byte = 1'b0;

        // Drain, then keep watching for stray results.
        while (pending != 0)
            @(posedge clk);
        repeat (10) @(posedge clk);

        $display("Run: %0d messages, %0d byte beats, %0d results checked.",
                 msgs_sent, beats_seen, results_seen);
        $display("Status codes seen (6..0): %b.", status_seen);
        if (fail_count == 0 && pending == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule

// ===== files.f =====
+incdir+rtl/core
rtl/core/dncv_pkg.sv
rtl/core/dncv_if.sv
rtl/core/dncv_front.sv
rtl/core/dncv_queue.sv
rtl/core/dncv_back.sv
rtl/core/dtls_new_cid_message_validator.sv
bench/dncv_result_checker.sv
bench/dtls_new_cid_message_validator_test.sv
